>>> rtl/brsc_pkg.sv
// Package with constants, codes and types of the battery relay safety controller.
`default_nettype none
package brsc_pkg;
   localparam int MonitorCount = 5;

   localparam logic [1:0] ST_SAFE     = 2'd0;
   localparam logic [1:0] ST_ENGAGED  = 2'd1;
   localparam logic [1:0] ST_CHARGING = 2'd2;
   localparam logic [1:0] ST_UNSAFE   = 2'd3;

   localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
   localparam logic [2:0] REG_BUS_MIN    = 3'd1;
   localparam logic [2:0] REG_PCT_NUM    = 3'd2;
   localparam logic [2:0] REG_PCT_DEN    = 3'd3;
   localparam logic [2:0] REG_PRE_DELAY  = 3'd4;
   localparam logic [2:0] REG_RECLOSE    = 3'd5;
   localparam logic [2:0] REG_BLEED_HOLD = 3'd6;

   localparam int CsrDataWidth = 20;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        imd_raw;
      logic        tsms_raw;
      logic        esdb_raw;
      logic        esdb_chg_raw;
      logic        charger_raw;
      logic [31:0] fault_bits;
      logic [7:0]  fault_events;
      logic        controller_active;
      logic [19:0] bus_mv;
      logic [19:0] pack_mv;
   } req_word_type;

   typedef struct packed {
      logic [1:0] safety_state;
      logic       precharge_closed;
      logic       bleed_closed;
      logic       charger_relay_closed;
      logic       permission_closed;
      logic       led_red;
      logic       led_green;
      logic       led_blue;
      logic [4:0] monitors_stable;
   } rsp_word_type;
endpackage
`default_nettype wire

>>> rtl/brsc_stream_if.sv
// Valid/ready stream interface carrying one word of a given type.
`default_nettype none
interface brsc_stream_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/battery_relay_safety_controller_top.sv
// Top level of the battery relay safety controller with its threshold divider.
//
// Usage: one request word is one task tick (time, raw monitor pins, fault
// status, bus and pack voltages). Each request yields exactly one response
// word with the safety state, relay drives, LEDs and debounced pins.
// The precharge threshold pack_mv * num / den is found by one shared
// restoring divider that produces one quotient bit per cycle over 28 bits.
// After a word is accepted, the divider steps through all 28 bits, then the
// update phase registers the response, and the response register is presented.
// The block accepts a new word only when idle, and a finished response
// stays in its output register while the receiver stalls; the next word
// is accepted at the earliest in the cycle after the response is taken.
// Reset puts the block in the unsafe state with a pending state entry, all
// relays open except permission, debounce history cleared and registers at
// their defaults. Configuration writes are taken at any time but are meant
// for idle periods.
`default_nettype none
module battery_relay_safety_controller_top
   import brsc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   brsc_stream_if.sink                  req,
   brsc_stream_if.source                rsp,
   input  wire logic                    csr_we,
   input  wire logic [2:0]              csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_data
);
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DIV  = 2'd1;
   localparam logic [1:0] PH_UPD  = 2'd2;
   localparam logic [1:0] PH_OUT  = 2'd3;

   // Configuration registers.
   logic [15:0] debounce_ff;
   logic [19:0] bus_min_ff;
   logic [7:0]  num_ff, den_ff;
   logic [15:0] pre_delay_ff;
   logic        reclose_ff, bleed_hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= 16'd100;
         bus_min_ff    <= 20'd5000;
         num_ff        <= 8'd90;
         den_ff        <= 8'd100;
         pre_delay_ff  <= 16'd750;
         reclose_ff    <= 1'b0;
         bleed_hold_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            REG_DEBOUNCE:   debounce_ff   <= csr_data[15:0];
            REG_BUS_MIN:    bus_min_ff    <= csr_data;
            REG_PCT_NUM:    num_ff        <= csr_data[7:0];
            REG_PCT_DEN:    den_ff        <= csr_data[7:0];
            REG_PRE_DELAY:  pre_delay_ff  <= csr_data[15:0];
            REG_RECLOSE:    reclose_ff    <= csr_data[0];
            REG_BLEED_HOLD: bleed_hold_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Sequencer, captured word and divider registers.
   logic [1:0]   phase_ff;
   logic [4:0]   cnt_ff;
   req_word_type word_ff;
   logic [27:0]  dvd_ff;
   logic [7:0]   rem_ff;
   logic         ms_ge_ff;
   logic [22:0]  ms_q_ff;
   rsp_word_type rsp_ff;

   logic [1:0]  mode_ff;
   logic        entry_ff, pre_ff, bleed_ff, chg_ff, open_ff;
   logic [31:0] eng_time_ff;
   logic [MonitorCount-1:0] last_ff, stable_ff;
   logic [31:0] chg_time_ff [MonitorCount];

   // One restoring divide step: remainder gets next dividend bit.
   logic [8:0]  trial;
   logic        fits;
   logic [27:0] product;
   always_comb begin
      trial   = {rem_ff, dvd_ff[27]};
      fits    = trial >= {1'b0, den_ff};
      product = {8'd0, req.data.pack_mv} * {20'd0, num_ff};
   end

   // Blink phase: now / 1000 by reciprocal multiplication in the first divide
   // cycle, then the residue from that quotient in the last divide cycle.
   logic [60:0] ms_prod;
   logic [31:0] ms_rem;
   always_comb begin
      ms_prod = {29'd0, word_ff.now_ms} * 61'd274877907;
      ms_rem  = word_ff.now_ms - {9'd0, ms_q_ff} * 32'd1000;
   end

   // Per-tick decision, evaluated in the update phase.
   logic [MonitorCount-1:0] raw, last_in, stable_in;
   logic [31:0] chg_time_in [MonitorCount];
   logic bms_ok, imd_ok, tsms, esdb, opto, active;
   logic bus_at_or_above, bus_at_or_below, ge_thr, lt_thr, keep_bleed;
   logic [31:0] thr;
   logic [1:0] ns;
   logic pre_in, bleed_in, open_in, entry_in;
   logic [1:0] mode_in;
   logic [31:0] eng_time_in;
   rsp_word_type rsp_in;
   always_comb begin
      raw = {word_ff.charger_raw, word_ff.esdb_chg_raw, word_ff.esdb_raw,
             word_ff.tsms_raw, word_ff.imd_raw};
      for (int k = 0; k < MonitorCount; k++) begin
         last_in[k]     = last_ff[k];
         stable_in[k]   = stable_ff[k];
         chg_time_in[k] = chg_time_ff[k];
         if (raw[k] != stable_ff[k]) begin
            if (raw[k] != last_ff[k]) begin
               last_in[k]     = raw[k];
               chg_time_in[k] = word_ff.now_ms;
            end else if ((word_ff.now_ms - chg_time_ff[k]) >= {16'd0, debounce_ff}) begin
               stable_in[k] = raw[k];
            end
         end else begin
            last_in[k] = raw[k];
         end
      end
      bms_ok = (word_ff.fault_bits == 32'd0) && (word_ff.fault_events == 8'd0);
      imd_ok = stable_in[0];
      tsms   = stable_in[1];
      esdb   = stable_in[2];
      opto   = stable_in[4];
      active = word_ff.controller_active;
      bus_at_or_above = word_ff.bus_mv >= bus_min_ff;
      bus_at_or_below = word_ff.bus_mv <= bus_min_ff;
      thr = (den_ff == 8'd0) ? 32'hFFFF_FFFF : {4'd0, dvd_ff};
      ge_thr = (word_ff.pack_mv != 20'd0) && ({12'd0, word_ff.bus_mv} >= thr);
      lt_thr = (word_ff.pack_mv != 20'd0) && ({12'd0, word_ff.bus_mv} < thr);

      open_in = open_ff;
      if (!bms_ok || !imd_ok || !active) open_in = 1'b1;
      else if (reclose_ff && open_ff) open_in = 1'b0;

      keep_bleed = bleed_hold_ff && (mode_ff == ST_CHARGING);
      bleed_in = bleed_ff;
      pre_in   = pre_ff;
      if (bleed_ff && bus_at_or_below && !keep_bleed) bleed_in = 1'b0;
      if (pre_ff && ge_thr) pre_in = 1'b0;

      if (!bms_ok || !imd_ok || !esdb || !active) ns = ST_UNSAFE;
      else if (opto) ns = ST_CHARGING;
      else if (!tsms) ns = ST_SAFE;
      else ns = ST_ENGAGED;

      mode_in  = mode_ff;
      entry_in = entry_ff;
      if (ns != mode_ff) begin
         mode_in  = ns;
         entry_in = 1'b1;
      end

      eng_time_in = eng_time_ff;
      if (entry_in) begin
         if (mode_in == ST_CHARGING && bleed_hold_ff) begin
            pre_in   = 1'b0;
            bleed_in = 1'b1;
         end else if (mode_in == ST_ENGAGED) begin
            bleed_in    = 1'b0;
            eng_time_in = word_ff.now_ms;
         end else begin
            pre_in = 1'b0;
            if (!bleed_in && bus_at_or_above) bleed_in = 1'b1;
         end
         entry_in = 1'b0;
      end

      if (mode_in == ST_ENGAGED && !pre_in &&
          (word_ff.now_ms - eng_time_in) >= {16'd0, pre_delay_ff} && lt_thr)
         pre_in = 1'b1;

      rsp_in.safety_state         = mode_in;
      rsp_in.precharge_closed     = pre_in;
      rsp_in.bleed_closed         = bleed_in;
      rsp_in.charger_relay_closed = opto;
      rsp_in.permission_closed    = !open_in;
      rsp_in.led_red   = 1'b0;
      rsp_in.led_green = 1'b0;
      rsp_in.led_blue  = 1'b0;
      case (mode_in)
         ST_UNSAFE:  rsp_in.led_red   = 1'b1;
         ST_SAFE:    rsp_in.led_green = ms_ge_ff ? 1'b0 : 1'b1;
         ST_ENGAGED: rsp_in.led_green = 1'b1;
         default:    rsp_in.led_blue  = 1'b1;
      endcase
      rsp_in.monitors_stable = stable_in[4:0];
   end

   assign req.ready = (phase_ff == PH_IDLE);
   assign rsp.valid = (phase_ff == PH_OUT);
   assign rsp.data  = rsp_ff;

   // Sequencer and shared divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         cnt_ff      <= 5'd0;
         mode_ff     <= ST_UNSAFE;
         entry_ff    <= 1'b1;
         pre_ff      <= 1'b0;
         bleed_ff    <= 1'b0;
         chg_ff      <= 1'b0;
         open_ff     <= 1'b0;
         eng_time_ff <= 32'd0;
         last_ff     <= '0;
         stable_ff   <= '0;
         for (int k = 0; k < MonitorCount; k++) chg_time_ff[k] <= 32'd0;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (req.valid) begin
                  word_ff  <= req.data;
                  dvd_ff   <= product;
                  rem_ff   <= 8'd0;
                  cnt_ff   <= 5'd27;
                  phase_ff <= PH_DIV;
               end
            end
            PH_DIV: begin
               rem_ff <= fits ? 8'(trial - {1'b0, den_ff}) : trial[7:0];
               dvd_ff <= {dvd_ff[26:0], fits};
               if (cnt_ff == 5'd27) ms_q_ff <= ms_prod[60:38];
               if (cnt_ff == 5'd0) begin
                  ms_ge_ff <= ms_rem[9:0] >= 10'd500;
                  phase_ff <= PH_UPD;
               end
               cnt_ff <= cnt_ff - 5'd1;
            end
            PH_UPD: begin
               rsp_ff      <= rsp_in;
               mode_ff     <= mode_in;
               entry_ff    <= entry_in;
               pre_ff      <= pre_in;
               bleed_ff    <= bleed_in;
               chg_ff      <= opto;
               open_ff     <= open_in;
               eng_time_ff <= eng_time_in;
               last_ff     <= last_in;
               stable_ff   <= stable_in;
               for (int k = 0; k < MonitorCount; k++) chg_time_ff[k] <= chg_time_in[k];
               phase_ff    <= PH_OUT;
            end
            default: begin
               if (rsp.ready) phase_ff <= PH_IDLE;
            end
         endcase
      end
   end

   // Checks on the sequencer and the relay logic.
   always_ff @(posedge clock) begin
      if (!reset) begin
         if (phase_ff == PH_DIV && cnt_ff > 5'd27)
            $error("divider step count out of range");
         if (phase_ff == PH_OUT && rsp_ff.led_red != (rsp_ff.safety_state == ST_UNSAFE))
            $error("red LED disagrees with state");
         if (phase_ff == PH_OUT && rsp_ff.charger_relay_closed != chg_ff)
            $error("charger relay disagrees with opto");
      end
   end

   property p_ready_idle;
      @(posedge clock) disable iff (reset) req.ready |-> !rsp.valid;
   endproperty
   a_ready_idle: assert property (p_ready_idle) else $error("ready while response pending");

   property p_hold;
      @(posedge clock) disable iff (reset) (rsp.valid && !rsp.ready) |=> $stable(rsp_ff);
   endproperty
   a_hold: assert property (p_hold) else $error("stalled response changed");

   property p_div_len;
      @(posedge clock) disable iff (reset)
         (req.valid && req.ready) |=> (phase_ff == PH_DIV) ##28 (phase_ff == PH_UPD);
   endproperty
   a_div_len: assert property (p_div_len) else $error("divider length wrong");

   property p_engaged_bleed;
      @(posedge clock) disable iff (reset)
         (rsp.valid && rsp_ff.safety_state == ST_ENGAGED && $rose(rsp.valid) &&
          entry_ff == 1'b0 && $past(mode_ff) != ST_ENGAGED) |-> !rsp_ff.bleed_closed;
   endproperty
   a_engaged_bleed: assert property (p_engaged_bleed) else $error("bleed closed on engage");
endmodule
`default_nettype wire

>>> bench/brsc_scoreboard.sv
// Scoreboard class that predicts controller responses and checks them in order.
import brsc_pkg::*;

class brsc_scoreboard;
   // Register copies.
   bit [15:0] debounce_ms;
   bit [19:0] bus_min_mv;
   bit [7:0]  pct_num;
   bit [7:0]  pct_den;
   bit [15:0] pre_delay_ms;
   bit        reclose;
   bit        bleed_hold;

   // Controller state copies.
   bit [1:0]  mode;
   bit        entry_due;
   bit        pre_on;
   bit        bleed_on;
   bit        perm_open;
   bit [31:0] engaged_at;
   bit [4:0]  pin_last;
   bit [4:0]  pin_stable;
   bit [31:0] pin_changed [5];

   rsp_word_type pending_rsp [$];
   int errors;

   function new();
      errors = 0;
      debounce_ms = 100;
      bus_min_mv = 5000;
      pct_num = 90;
      pct_den = 100;
      pre_delay_ms = 750;
      reclose = 0;
      bleed_hold = 1;
      mode = ST_UNSAFE;
      entry_due = 1;
      pre_on = 0;
      bleed_on = 0;
      perm_open = 0;
      engaged_at = 0;
      pin_last = 0;
      pin_stable = 0;
      foreach (pin_changed[k]) pin_changed[k] = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [19:0] val);
      case (idx)
         REG_DEBOUNCE:   debounce_ms = val[15:0];
         REG_BUS_MIN:    bus_min_mv = val;
         REG_PCT_NUM:    pct_num = val[7:0];
         REG_PCT_DEN:    pct_den = val[7:0];
         REG_PRE_DELAY:  pre_delay_ms = val[15:0];
         REG_RECLOSE:    reclose = val[0];
         REG_BLEED_HOLD: bleed_hold = val[0];
         default: ;
      endcase
   endfunction

   // Advance the prediction by one tick and queue the expected word.
   function void note_tick(req_word_type w);
      bit [4:0] raw;
      bit [31:0] thr;
      bit bms_ok, bus_ge, bus_le, ge_thr, lt_thr, keep;
      bit [1:0] ns;
      rsp_word_type r;
      raw = {w.charger_raw, w.esdb_chg_raw, w.esdb_raw, w.tsms_raw, w.imd_raw};
      for (int k = 0; k < 5; k++) begin
         if (raw[k] != pin_stable[k]) begin
            if (raw[k] != pin_last[k]) begin
               pin_last[k] = raw[k];
               pin_changed[k] = w.now_ms;
            end else if (32'(w.now_ms - pin_changed[k]) >= debounce_ms) begin
               pin_stable[k] = raw[k];
            end
         end else begin
            pin_last[k] = raw[k];
         end
      end
      bms_ok = (w.fault_bits == 0) && (w.fault_events == 0);
      bus_ge = w.bus_mv >= bus_min_mv;
      bus_le = w.bus_mv <= bus_min_mv;
      if (pct_den == 0) thr = '1;
      else thr = (32'(w.pack_mv) * pct_num) / pct_den;
      ge_thr = (w.pack_mv != 0) && (w.bus_mv >= thr);
      lt_thr = (w.pack_mv != 0) && (w.bus_mv < thr);
      if (!bms_ok || !pin_stable[0] || !w.controller_active) perm_open = 1;
      else if (reclose && perm_open) perm_open = 0;
      keep = bleed_hold && (mode == ST_CHARGING);
      if (bleed_on && bus_le && !keep) bleed_on = 0;
      if (pre_on && ge_thr) pre_on = 0;
      if (!bms_ok || !pin_stable[0] || !pin_stable[2] || !w.controller_active)
         ns = ST_UNSAFE;
      else if (pin_stable[4]) ns = ST_CHARGING;
      else if (!pin_stable[1]) ns = ST_SAFE;
      else ns = ST_ENGAGED;
      if (ns != mode) begin
         mode = ns;
         entry_due = 1;
      end
      // State entry actions.
      if (entry_due) begin
         if (mode == ST_CHARGING && bleed_hold) begin
            pre_on = 0;
            bleed_on = 1;
         end else if (mode == ST_ENGAGED) begin
            bleed_on = 0;
            engaged_at = w.now_ms;
         end else begin
            pre_on = 0;
            if (bus_ge) bleed_on = 1;
         end
         entry_due = 0;
      end
      if (mode == ST_ENGAGED && !pre_on &&
          32'(w.now_ms - engaged_at) >= pre_delay_ms && lt_thr)
         pre_on = 1;
      r = '0;
      r.safety_state = mode;
      r.precharge_closed = pre_on;
      r.bleed_closed = bleed_on;
      r.charger_relay_closed = pin_stable[4];
      r.permission_closed = !perm_open;
      case (mode)
         ST_UNSAFE:  r.led_red = 1;
         ST_SAFE:    r.led_green = (w.now_ms % 1000) < 500;
         ST_ENGAGED: r.led_green = 1;
         default:    r.led_blue = 1;
      endcase
      r.monitors_stable = pin_stable;
      pending_rsp.push_back(r);
   endfunction

   function void check_rsp(rsp_word_type got);
      rsp_word_type exp_w;
      if (pending_rsp.size() == 0) begin
         $display("%0t: unexpected response %h", $time, got);
         errors++;
         return;
      end
      exp_w = pending_rsp.pop_front();
      if (got !== exp_w) begin
         $display("%0t: mismatch expected %h actual %h", $time, exp_w, got);
         errors++;
      end
   endfunction
endclass

>>> bench/battery_relay_safety_controller_top_test.sv
// Top module of the battery relay safety controller testbench.
module battery_relay_safety_controller_top_test;
   import brsc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 5000;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [2:0] csr_index = 0;
   logic [19:0] csr_data = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;
   bit [31:0] now_ms = 0;
   bit [4:0] pins = 0;
   brsc_scoreboard tick_board;

   brsc_stream_if #(.word_type(req_word_type)) req_ch ();
   brsc_stream_if #(.word_type(rsp_word_type)) rsp_ch ();

   battery_relay_safety_controller_top i_dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.data = '0;
      rsp_ch.ready = 0;
   end

   // Receiver: random stalls, checks each taken word.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) tick_board.check_rsp(rsp_ch.data);
   end
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on cycles with no handshake.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else if (!reset)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("FAIL battery_relay_safety_controller_top");
         $finish;
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [19:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_data <= val;
      tick_board.write_reg(idx, val);
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic wait_drained();
      while (tick_board.pending_rsp.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Send one word, holding valid until accepted.
   task automatic send_tick(req_word_type w);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_ch.valid <= 1;
      req_ch.data <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tick_board.note_tick(w);
      @(negedge clock);
      req_ch.valid <= 0;
   endtask

   // Random tick: mostly healthy, time advancing so debounce completes.
   task automatic random_tick(int mode_sel);
      req_word_type w;
      int unsigned bus_val;
      now_ms += (($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 400));
      if ($urandom_range(5) == 0) pins = 5'($urandom);
      else if ($urandom_range(3) == 0) pins[$urandom_range(4)] ^= 1;
      w.now_ms = now_ms;
      {w.charger_raw, w.esdb_chg_raw, w.esdb_raw, w.tsms_raw, w.imd_raw} = pins;
      w.fault_bits = ($urandom_range(9) == 0) ? (32'd1 << $urandom_range(31)) |
                     (($urandom_range(1)) ? $urandom : 0) : 0;
      w.fault_events = ($urandom_range(14) == 0) ? 8'($urandom) : 8'd0;
      w.controller_active = ($urandom_range(14) != 0);
      w.pack_mv = ($urandom_range(9) == 0) ? 20'd0 : 20'($urandom_range(1048575));
      if (mode_sel == 0) bus_val = $urandom_range(1048575);
      else bus_val = w.pack_mv * $urandom_range(120) / 100;
      if (bus_val > 1048575) bus_val = 1048575;
      w.bus_mv = 20'(bus_val);
      send_tick(w);
   endtask

   initial begin
      req_word_type w;
      tick_board = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: extremes, debounce, every state, zero pack.
      write_csr(REG_DEBOUNCE, 20'd0);
      for (int i = 0; i < 20; i++) begin
         w = '0;
         w.now_ms = (i < 2) ? 32'hFFFF_FFF0 + i * 8 : i * 300;
         w.imd_raw = (i != 5);
         w.esdb_raw = 1;
         w.tsms_raw = (i >= 8);
         w.charger_raw = (i >= 6 && i < 8) || i == 19;
         w.esdb_chg_raw = i[0];
         w.controller_active = (i != 3);
         w.fault_bits = (i == 1) ? 32'hFFFF_FFFF : 32'd0;
         w.fault_events = (i == 2) ? 8'hFF : 8'd0;
         w.pack_mv = 20'((i == 10) ? 0 : (i == 11 ? 20'hFFFFF : 100000));
         w.bus_mv = 20'((i == 12) ? 20'hFFFFF : (i * 5000));
         send_tick(w);
      end
      wait_drained();

      // Configuration phases with idling patterns.
      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         case (ph)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 59; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 59; end
            3: begin send_idle_pct = 19; recv_idle_pct = 19; end
            default: begin send_idle_pct = $urandom_range(30); recv_idle_pct = 10; end
         endcase
         write_csr(REG_DEBOUNCE,
                   20'((ph == 5) ? 16'hFFFF : (ph == 0 ? 0 : $urandom_range(300))));
         write_csr(REG_BUS_MIN,
                   20'((ph == 1) ? 20'hFFFFF : (ph == 2 ? 0 : $urandom_range(1048575))));
         write_csr(REG_PCT_NUM, 20'((ph == 3) ? 0 : (ph == 4 ? 255 : $urandom_range(255))));
         write_csr(REG_PCT_DEN, 20'((ph == 4) ? 0 : (ph == 1 ? 255 : $urandom_range(1, 255))));
         write_csr(REG_PRE_DELAY,
                   20'((ph == 2) ? 16'hFFFF : (ph == 0 ? 0 : $urandom_range(1000))));
         write_csr(REG_RECLOSE, 20'(ph[0]));
         write_csr(REG_BLEED_HOLD, 20'(ph[1]));
         for (int i = 0; i < 275; i++) begin
            random_tick($urandom_range(1));
            // Sender holds off until everything is answered, once per phase.
            if (i == 100) while (tick_board.pending_rsp.size() != 0) @(negedge clock);
         end
      end

      wait_drained();
      if (tick_board.errors == 0)
         $display("PASS battery_relay_safety_controller_top");
      else
         $display("FAIL battery_relay_safety_controller_top");
      $finish;
   end
endmodule
